// ===== sv/expression_tokenizer_top_assert.svh =====
// Assertion helpers for the expression tokenizer.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef EXPRESSION_TOKENIZER_TOP_ASSERT_SVH
`define EXPRESSION_TOKENIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETOK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("expression tokenizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define ETOK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("expression tokenizer check failed");

`endif

// ===== sv/etok_pkg.sv =====
package etok_pkg;

    // Width of the internal character index.
    localparam int POSITION_BITS = 16;
    localparam int POS_OUT_BITS  = 16;

    // Token type codes.
    localparam logic [3:0] TOK_NUMBER  = 4'd0;
    localparam logic [3:0] TOK_IDENT   = 4'd1;
    localparam logic [3:0] TOK_KEYWORD = 4'd2;
    localparam logic [3:0] TOK_PLUS    = 4'd3;
    localparam logic [3:0] TOK_MINUS   = 4'd4;
    localparam logic [3:0] TOK_MUL     = 4'd5;
    localparam logic [3:0] TOK_DIV     = 4'd6;
    localparam logic [3:0] TOK_LPAREN  = 4'd7;
    localparam logic [3:0] TOK_RPAREN  = 4'd8;
    localparam logic [3:0] TOK_COLON   = 4'd9;
    localparam logic [3:0] TOK_EQ      = 4'd10;
    localparam logic [3:0] TOK_EOF     = 4'd11;
    localparam logic [3:0] TOK_ILLEGAL = 4'd12;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_EOT    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;

    // Length of the keyword "solve".
    localparam logic [2:0] KW_LEN = 3'd5;

    // Lexer modes, one-hot.
    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_NUM  = 4'b0010,
        MODE_ID   = 4'b0100,
        MODE_ERR  = 4'b1000
    } etok_mode_t;

    // One result item.
    typedef struct packed {
        logic [3:0]              token_type;
        logic [7:0]              text_char;
        logic                    has_char;
        logic                    token_done;
        logic [POS_OUT_BITS-1:0] position;
        logic                    last_result;
    } etok_result_t;

    // Everything one character produces: up to two results in order.
    typedef struct packed {
        logic         first_valid;
        logic         second_valid;
        etok_result_t first;
        etok_result_t second;
    } etok_step_t;

    // Character of the keyword at a given offset.
    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h73;
            3'd1:    ch = 8'h6F;
            3'd2:    ch = 8'h6C;
            3'd3:    ch = 8'h76;
            3'd4:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Clamp an index to the width of the position field.
    function automatic logic [POS_OUT_BITS-1:0] to_position(
        input logic [POSITION_BITS-1:0] idx
    );
        logic [31:0] wide;
        wide = 32'(idx);
        if (wide > 32'(2 ** POS_OUT_BITS - 1)) begin
            return '1;
        end
        return wide[POS_OUT_BITS-1:0];
    endfunction

endpackage

// ===== sv/etok_ifs.sv =====
// Character channel into the tokenizer.
interface etok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

// Token channel out of the tokenizer.
interface etok_token_if;
    logic                              valid;
    logic                              ready;
    logic [3:0]                        token_type;
    logic [7:0]                        text_char;
    logic                              has_char;
    logic                              token_done;
    logic [etok_pkg::POS_OUT_BITS-1:0] position;
    logic                              last_result;

    modport source (
        output valid, output token_type, output text_char, output has_char,
        output token_done, output position, output last_result, input ready
    );
    modport sink (
        input valid, input token_type, input text_char, input has_char,
        input token_done, input position, input last_result, output ready
    );
endinterface

// ===== sv/etok_lexer.sv =====
// Lexer state and the combinational step that turns one character into
// zero, one or two results. State advances only when step_en is high.
module etok_lexer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  logic [7:0]          char_in,
    output etok_pkg::etok_step_t step
);

    localparam int PB = etok_pkg::POSITION_BITS;

    etok_pkg::etok_mode_t mode_reg, mode_next;
    logic                 dot_reg, dot_next;
    logic [2:0]           prog_reg, prog_next;
    logic                 miss_reg, miss_next;
    logic [PB-1:0]        index_reg, index_next;
    logic [PB-1:0]        start_reg, start_next;

    logic                   is_digit, is_letter, is_punct;
    logic                   cont_valid, close_valid, fresh_valid, eot;
    logic [3:0]             punct_type;
    logic [PB-1:0]          index_inc;
    etok_pkg::etok_result_t cont_res, close_res, fresh_res;

    // Build a result with last_result cleared.
    function automatic etok_pkg::etok_result_t make_result(
        input logic [3:0]    ttype,
        input logic [7:0]    ch,
        input logic          has,
        input logic          done,
        input logic [PB-1:0] pos
    );
        etok_pkg::etok_result_t r;
        r.token_type  = ttype;
        r.text_char   = ch;
        r.has_char    = has;
        r.token_done  = done;
        r.position    = etok_pkg::to_position(pos);
        r.last_result = 1'b0;
        return r;
    endfunction

    // Character classes.
    assign is_digit  = (char_in >= 8'h30) && (char_in <= 8'h39);
    assign is_letter = ((char_in >= 8'h61) && (char_in <= 8'h7A)) ||
                       ((char_in >= 8'h41) && (char_in <= 8'h5A));

    always_comb
    begin
        is_punct = 1'b1;
        unique case (char_in)
            etok_pkg::CH_PLUS:   punct_type = etok_pkg::TOK_PLUS;
            etok_pkg::CH_MINUS:  punct_type = etok_pkg::TOK_MINUS;
            etok_pkg::CH_STAR:   punct_type = etok_pkg::TOK_MUL;
            etok_pkg::CH_SLASH:  punct_type = etok_pkg::TOK_DIV;
            etok_pkg::CH_LPAREN: punct_type = etok_pkg::TOK_LPAREN;
            etok_pkg::CH_RPAREN: punct_type = etok_pkg::TOK_RPAREN;
            etok_pkg::CH_COLON:  punct_type = etok_pkg::TOK_COLON;
            etok_pkg::CH_EQUAL:  punct_type = etok_pkg::TOK_EQ;
            default:
            begin
                punct_type = etok_pkg::TOK_ILLEGAL;
                is_punct   = 1'b0;
            end
        endcase
    end

    // Saturating increment of the character index.
    assign index_inc = (index_reg == {PB{1'b1}}) ? index_reg
                                                 : index_reg + {{(PB-1){1'b0}}, 1'b1};

    // One lexer step: continue or close a pending token, then, outside the error mode,
    // handle the character as the start of a new item if it did not continue one.
    always_comb
    begin
        mode_next   = mode_reg;
        dot_next    = dot_reg;
        prog_next   = prog_reg;
        miss_next   = miss_reg;
        start_next  = start_reg;
        index_next  = index_inc;
        cont_valid  = 1'b0;
        close_valid = 1'b0;
        fresh_valid = 1'b0;
        eot         = 1'b0;
        cont_res    = '0;
        close_res   = '0;
        fresh_res   = '0;

        unique case (mode_reg)
            etok_pkg::MODE_NUM:
            begin
                if (is_digit || ((char_in == etok_pkg::CH_DOT) && !dot_reg)) begin
                    cont_valid = 1'b1;
                    if (char_in == etok_pkg::CH_DOT) begin
                        dot_next = 1'b1;
                    end
                    cont_res = make_result(etok_pkg::TOK_NUMBER, char_in, 1'b1, 1'b0,
                                           start_reg);
                end else begin
                    close_valid = 1'b1;
                    close_res   = make_result(etok_pkg::TOK_NUMBER, 8'h00, 1'b0, 1'b1,
                                              start_reg);
                    mode_next   = etok_pkg::MODE_IDLE;
                end
            end
            etok_pkg::MODE_ID:
            begin
                if (is_letter || (char_in == etok_pkg::CH_UNDER)) begin
                    cont_valid = 1'b1;
                    if ((prog_reg < etok_pkg::KW_LEN) &&
                        (char_in == etok_pkg::kw_char(prog_reg))) begin
                        prog_next = prog_reg + 3'd1;
                    end else begin
                        miss_next = 1'b1;
                    end
                    cont_res = make_result(etok_pkg::TOK_IDENT, char_in, 1'b1, 1'b0,
                                           start_reg);
                end else begin
                    close_valid = 1'b1;
                    close_res   = make_result(
                        ((prog_reg == etok_pkg::KW_LEN) && !miss_reg)
                            ? etok_pkg::TOK_KEYWORD : etok_pkg::TOK_IDENT,
                        8'h00, 1'b0, 1'b1, start_reg);
                    mode_next   = etok_pkg::MODE_IDLE;
                end
            end
            etok_pkg::MODE_ERR:
            begin
                // Drop everything up to the end of text.
                if (char_in == etok_pkg::CH_EOT) begin
                    mode_next  = etok_pkg::MODE_IDLE;
                    index_next = '0;
                end
            end
            default:
            begin
            end
        endcase

        // Start of a new item.
        if ((mode_reg != etok_pkg::MODE_ERR) && !cont_valid) begin
            if (char_in == etok_pkg::CH_EOT) begin
                eot         = 1'b1;
                fresh_valid = 1'b1;
                fresh_res   = make_result(etok_pkg::TOK_EOF, 8'h00, 1'b0, 1'b1, index_reg);
            end else if ((char_in == etok_pkg::CH_TAB) || (char_in == etok_pkg::CH_SPACE)) begin
                fresh_valid = 1'b0;
            end else if (is_digit) begin
                mode_next   = etok_pkg::MODE_NUM;
                dot_next    = 1'b0;
                start_next  = index_reg;
                fresh_valid = 1'b1;
                fresh_res   = make_result(etok_pkg::TOK_NUMBER, char_in, 1'b1, 1'b0,
                                          index_reg);
            end else if (is_letter) begin
                mode_next   = etok_pkg::MODE_ID;
                prog_next   = (char_in == etok_pkg::kw_char(3'd0)) ? 3'd1 : 3'd0;
                miss_next   = (char_in != etok_pkg::kw_char(3'd0));
                start_next  = index_reg;
                fresh_valid = 1'b1;
                fresh_res   = make_result(etok_pkg::TOK_IDENT, char_in, 1'b1, 1'b0,
                                          index_reg);
            end else if (is_punct) begin
                fresh_valid = 1'b1;
                fresh_res   = make_result(punct_type, 8'h00, 1'b0, 1'b1, index_reg);
            end else begin
                mode_next   = etok_pkg::MODE_ERR;
                fresh_valid = 1'b1;
                fresh_res   = make_result(etok_pkg::TOK_ILLEGAL, char_in, 1'b1, 1'b1,
                                          index_reg);
            end
            if (eot) begin
                index_next = '0;
            end
        end
    end

    // Order the results: a closing result always comes first.
    always_comb
    begin
        step.first_valid  = cont_valid || close_valid || fresh_valid;
        step.second_valid = close_valid && fresh_valid;
        if (close_valid) begin
            step.first = close_res;
        end else if (cont_valid) begin
            step.first = cont_res;
        end else begin
            step.first = fresh_res;
        end
        step.first.last_result  = !(close_valid && fresh_valid);
        step.second             = fresh_res;
        step.second.last_result = 1'b1;
    end

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= etok_pkg::MODE_IDLE;
            dot_reg   <= 1'b0;
            prog_reg  <= 3'd0;
            miss_reg  <= 1'b0;
            index_reg <= '0;
            start_reg <= '0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            dot_reg   <= dot_next;
            prog_reg  <= prog_next;
            miss_reg  <= miss_next;
            index_reg <= index_next;
            start_reg <= start_next;
        end
    end

endmodule

// ===== sv/expression_tokenizer_top.sv =====
// Channel  | Role   | Payload
// ---------+--------+----------------------------------------------------------
// chars    | sink   | char_in
// tokens   | source | token_type, text_char, has_char, token_done, position,
//          |        | last_result
//
// One character is taken per cycle while the spare register is empty and the output
// does not stall. It waits in the character stage; its results are then registered.
// A character that closes a token and starts another gives two results; the second
// waits in a spare register and holds the character stage until it moves out.
// Reset (rst_n low, asynchronous) empties all stages and returns the lexer to idle
// with index 0. A stall on tokens backs up into chars with no loss.
`include "expression_tokenizer_top_assert.svh"

module expression_tokenizer_top (
    input  logic               clk,
    input  logic               rst_n,
    etok_char_if.sink          chars,
    etok_token_if.source       tokens
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_char_reg;
    logic                   out_valid_reg, out_valid_next;
    etok_pkg::etok_result_t out_reg, out_next;
    logic                   spare_valid_reg, spare_valid_next;
    etok_pkg::etok_result_t spare_reg, spare_next;

    logic                 out_free, issue, in_accept;
    etok_pkg::etok_step_t step;

    // Handshake and issue control.
    assign out_free    = !out_valid_reg || tokens.ready;
    assign issue       = in_valid_reg && !spare_valid_reg && out_free;
    assign chars.ready = !in_valid_reg || issue;
    assign in_accept   = chars.valid && chars.ready;

    etok_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (issue),
        .char_in (in_char_reg),
        .step    (step)
    );

    // Next state of the character stage and the result buffer.
    always_comb
    begin
        in_valid_next    = in_accept ? 1'b1 : (issue ? 1'b0 : in_valid_reg);
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        spare_valid_next = spare_valid_reg;
        spare_next       = spare_reg;
        if (issue) begin
            out_valid_next   = step.first_valid;
            out_next         = step.first;
            spare_valid_next = step.second_valid;
            spare_next       = step.second;
        end else if (spare_valid_reg && out_free) begin
            out_valid_next   = 1'b1;
            out_next         = spare_reg;
            spare_valid_next = 1'b0;
        end else if (out_valid_reg && tokens.ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            in_char_reg <= chars.char_in;
        end
        out_reg   <= out_next;
        spare_reg <= spare_next;
    end

    // Output request.
    assign tokens.valid       = out_valid_reg;
    assign tokens.token_type  = out_reg.token_type;
    assign tokens.text_char   = out_reg.text_char;
    assign tokens.has_char    = out_reg.has_char;
    assign tokens.token_done  = out_reg.token_done;
    assign tokens.position    = out_reg.position;
    assign tokens.last_result = out_reg.last_result;

    // A shown result that is not the last of its character has its partner
    // waiting in the spare register.
    `ETOK_ASSERT_NOW(a_partner_waits, out_valid_reg && !out_reg.last_result, spare_valid_reg)
    // The spare register only ever holds the second result of a pair.
    `ETOK_ASSERT_NOW(a_spare_is_last, spare_valid_reg, spare_reg.last_result && out_valid_reg)
    // A character with two results parks the second one.
    `ETOK_ASSERT_NEXT(a_pair_parked, issue && step.second_valid, spare_valid_reg)

endmodule
